@@ rtl/core/swfa_pkg.sv @@
// ----------------------------------------------------------------------------
// swfa_pkg
// Shared types, constants and helpers of the sync word frame aligner.
// ----------------------------------------------------------------------------
`default_nettype none

package swfa_pkg;

  localparam int MAX_SYNC_BITS = 64;
  localparam int LEN_W         = 7;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 64;

  localparam logic [7:0]       HDR_BYTE0         = 8'hED;
  localparam logic [7:0]       HDR_BYTE1         = 8'hE2;
  localparam logic [7:0]       HDR_BYTE_COUNT    = 8'd2;
  localparam logic [7:0]       MAX_BYTE_COUNT    = 8'hFF;
  localparam logic [2:0]       FIRST_BIT_COUNT   = 3'd3;
  localparam logic [LEN_W-1:0] SYNC_LENGTH_RESET = 7'd16;
  localparam logic [7:0]       FRAME_BYTES_RESET = 8'd104;

  localparam logic [1:0] REG_SYNC_PATTERN = 2'd0;
  localparam logic [1:0] REG_SYNC_LENGTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_BYTES  = 2'd2;

  localparam logic KIND_MARKER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef enum logic [1:0] {
    SLOT_BYTE,
    SLOT_MARK,
    SLOT_HDR0,
    SLOT_HDR1
  } slot_t;

  typedef struct packed {
    logic [MAX_SYNC_BITS-1:0] hist;
    logic [7:0]               acc;
    logic [2:0]               bit_count;
    logic [7:0]               byte_count;
    logic                     in_frame;
    logic                     pol;
  } state_t;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  byte_val;
    logic        byte_inv;
    logic        has_sync;
    logic        sync_inv;
    logic [31:0] ts;
  } rec_t;

  function automatic logic [MAX_SYNC_BITS-1:0] sync_mask(input logic [LEN_W-1:0] len);
    logic [MAX_SYNC_BITS-1:0] m;
    if (len >= LEN_W'(MAX_SYNC_BITS)) begin
      m = '1;
    end else begin
      m = (MAX_SYNC_BITS'(1) << len) - MAX_SYNC_BITS'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/swfa_step.sv @@
// ----------------------------------------------------------------------------
// swfa_step
// Next-state and result record for one received bit.
// ----------------------------------------------------------------------------
`default_nettype none

module swfa_step (
  input  swfa_pkg::state_t                          cur,
  input  logic                                      bit_value,
  input  logic [31:0]                               time_stamp,
  input  logic [swfa_pkg::MAX_SYNC_BITS-1:0]        sync_pattern,
  input  logic [swfa_pkg::MAX_SYNC_BITS-1:0]        mask,
  input  logic [7:0]                                frame_bytes,
  output swfa_pkg::state_t                          nxt,
  output swfa_pkg::rec_t                            rec
);

  logic                                 b;
  logic [7:0]                           acc_sh;
  logic [swfa_pkg::MAX_SYNC_BITS-1:0]   diff;

  always_comb begin
    nxt          = cur;
    rec.has_byte = 1'b0;
    rec.byte_val = '0;
    rec.byte_inv = cur.pol;
    rec.has_sync = 1'b0;
    rec.sync_inv = 1'b0;
    rec.ts       = time_stamp;
    b            = bit_value ^ cur.pol;
    acc_sh       = {cur.acc[6:0], b};

    if (cur.in_frame) begin
      nxt.acc       = acc_sh;
      nxt.bit_count = cur.bit_count + 3'd1;
      if (nxt.bit_count == 3'd0) begin
        rec.has_byte = 1'b1;
        rec.byte_val = acc_sh;
        nxt.acc      = '0;
        if (cur.byte_count != swfa_pkg::MAX_BYTE_COUNT) begin
          nxt.byte_count = cur.byte_count + 8'd1;
        end
        if (nxt.byte_count >= frame_bytes) begin
          nxt.in_frame = 1'b0;
        end
      end
    end

    nxt.hist = {cur.hist[swfa_pkg::MAX_SYNC_BITS-2:0], bit_value};
    diff     = (nxt.hist ^ sync_pattern) & mask;

    if (!nxt.in_frame && (diff == '0 || diff == mask)) begin
      rec.has_sync   = 1'b1;
      rec.sync_inv   = (diff != '0);
      nxt.pol        = (diff != '0);
      nxt.byte_count = swfa_pkg::HDR_BYTE_COUNT;
      nxt.in_frame   = 1'b1;
      nxt.bit_count  = swfa_pkg::FIRST_BIT_COUNT;
      nxt.acc        = '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/swfa_emit.sv @@
// ----------------------------------------------------------------------------
// swfa_emit
// Two-entry record queue and serializer that sends each record as beats.
// ----------------------------------------------------------------------------
`default_nettype none

module swfa_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  swfa_pkg::rec_t      rec_in,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                item_kind,
  output logic [7:0]          data_byte,
  output logic                inverted,
  output logic [31:0]         start_time,
  output logic                last
);

  swfa_pkg::rec_t   q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic [1:0]       phase;
  swfa_pkg::rec_t   head;
  swfa_pkg::slot_t  slot;
  logic [2:0]       n_items;
  logic             pop;
  logic             beat;

  assign has_room  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign head      = q[rd_ptr];
  assign slot      = swfa_pkg::slot_t'(head.has_byte ? phase : phase + 2'd1);
  assign n_items   = {2'b00, head.has_byte} + (head.has_sync ? 3'd3 : 3'd0);
  assign last      = ({1'b0, phase} == n_items - 3'd1);
  assign beat      = out_valid && out_ready;
  assign pop       = beat && last;

  always_comb begin
    item_kind  = swfa_pkg::KIND_DATA;
    data_byte  = '0;
    inverted   = head.sync_inv;
    start_time = '0;
    case (slot)
      swfa_pkg::SLOT_BYTE: begin
        data_byte = head.byte_val;
        inverted  = head.byte_inv;
      end
      swfa_pkg::SLOT_MARK: begin
        item_kind  = swfa_pkg::KIND_MARKER;
        start_time = head.ts;
      end
      swfa_pkg::SLOT_HDR0: begin
        data_byte = swfa_pkg::HDR_BYTE0;
      end
      swfa_pkg::SLOT_HDR1: begin
        data_byte = swfa_pkg::HDR_BYTE1;
      end
      default: begin
        data_byte = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= rec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
      phase  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        phase  <= '0;
      end else if (beat) begin
        phase <= phase + 2'd1;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sync_word_frame_aligner.sv @@
// ----------------------------------------------------------------------------
// sync_word_frame_aligner
// Finds a sync word (true or inverted) in a bit stream and packs the frame
// that follows into bytes, led by a frame-start beat and two header bytes.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Payload
//   in        sink       in_valid / in_ready   bit_value, time_stamp
//   out       source     out_valid / out_ready item_kind, data_byte, inverted,
//                                              start_time, last
//   config    APB slave  psel/penable/pwrite   paddr, pwdata, prdata
//
// A bit is taken whenever the two-record result queue has room.
// Each bit yields zero to four beats, sent one per cycle from the queue while out_ready is high.
// Reset is synchronous and clears all state but the queue storage at once; no clearing pass.
// A stalled output holds its beat while the queue still takes bits as long as it has room.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_word_frame_aligner (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              bit_value,
  input  logic [31:0]                       time_stamp,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              item_kind,
  output logic [7:0]                        data_byte,
  output logic                              inverted,
  output logic [31:0]                       start_time,
  output logic                              last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swfa_pkg::ADDR_W-1:0]       paddr,
  input  logic [swfa_pkg::DATA_W-1:0]       pwdata,
  output logic [swfa_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  logic [swfa_pkg::MAX_SYNC_BITS-1:0]  sync_pattern;
  logic [swfa_pkg::LEN_W-1:0]          sync_length;
  logic [swfa_pkg::MAX_SYNC_BITS-1:0]  mask;
  logic [7:0]                          frame_bytes;
  logic                                wr_en;
  logic [1:0]                          reg_idx;
  swfa_pkg::state_t                    state;
  swfa_pkg::state_t                    state_next;
  swfa_pkg::rec_t                      rec;
  logic                                accept;
  logic                                push;

  assign pready  = 1'b1;
  assign reg_idx = paddr[swfa_pkg::ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      swfa_pkg::REG_SYNC_PATTERN: prdata = sync_pattern;
      swfa_pkg::REG_SYNC_LENGTH:  prdata = swfa_pkg::DATA_W'(sync_length);
      swfa_pkg::REG_FRAME_BYTES:  prdata = swfa_pkg::DATA_W'(frame_bytes);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern <= '0;
      sync_length  <= swfa_pkg::SYNC_LENGTH_RESET;
      mask         <= swfa_pkg::sync_mask(swfa_pkg::SYNC_LENGTH_RESET);
      frame_bytes  <= swfa_pkg::FRAME_BYTES_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        swfa_pkg::REG_SYNC_PATTERN: begin
          sync_pattern <= pwdata[swfa_pkg::MAX_SYNC_BITS-1:0];
        end
        swfa_pkg::REG_SYNC_LENGTH: begin
          sync_length <= pwdata[swfa_pkg::LEN_W-1:0];
          mask        <= swfa_pkg::sync_mask(pwdata[swfa_pkg::LEN_W-1:0]);
        end
        swfa_pkg::REG_FRAME_BYTES: begin
          frame_bytes <= pwdata[7:0];
        end
        default: begin
          sync_length <= sync_length;
        end
      endcase
    end
  end

  swfa_step u_step (
    .cur          (state),
    .bit_value    (bit_value),
    .time_stamp   (time_stamp),
    .sync_pattern (sync_pattern),
    .mask         (mask),
    .frame_bytes  (frame_bytes),
    .nxt          (state_next),
    .rec          (rec)
  );

  assign accept = in_valid && in_ready;
  assign push   = accept && (rec.has_byte || rec.has_sync);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  swfa_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .rec_in     (rec),
    .has_room   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .item_kind  (item_kind),
    .data_byte  (data_byte),
    .inverted   (inverted),
    .start_time (start_time),
    .last       (last)
  );

endmodule

`default_nettype wire

@@ rtl/core/swfa_checker.sv @@
// ----------------------------------------------------------------------------
// swfa_checker
// Port-level checks of the frame aligner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swfa_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_ready,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        item_kind,
  input  logic [7:0]  data_byte,
  input  logic        inverted,
  input  logic [31:0] start_time,
  input  logic        last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(data_byte)
      && $stable(inverted) && $stable(start_time) && $stable(last))
    else $error("Output beat changed while stalled.");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid right after reset.");

  a_marker_then_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && item_kind == swfa_pkg::KIND_MARKER |=>
      out_valid && item_kind == swfa_pkg::KIND_DATA && data_byte == swfa_pkg::HDR_BYTE0)
    else $error("Frame-start beat not followed by the first header byte.");

  a_marker_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == swfa_pkg::KIND_MARKER |-> !last)
    else $error("Frame-start beat marked as last.");

  a_full_implies_pending: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("Input stalled with no output pending.");

endmodule

bind sync_word_frame_aligner swfa_checker u_swfa_checker (.*);

`default_nettype wire
